/* design/nrgp_pkg.sv */
package nrgp_pkg;

    typedef enum logic [1:0] {
        KIND_RMC = 2'd0,
        KIND_GGA = 2'd1,
        KIND_GSV = 2'd2
    } nrgp_kind_t;

    // one finished sentence, front to back
    typedef struct packed {
        nrgp_kind_t         kind;
        logic               status;
        logic [14:0]        lat_int;
        logic [19:0]        lat_frac;
        logic [14:0]        lon_int;
        logic [19:0]        lon_frac;
        logic signed [20:0] alt;
    } nrgp_evt_t;

    // front/queue handshake
    typedef struct packed {
        logic push;
        logic full;
    } nrgp_qctl_t;

    localparam logic [31:0] HDR_RMC = 32'h524D432C;
    localparam logic [31:0] HDR_GGA = 32'h4747412C;
    localparam logic [31:0] HDR_GSV = 32'h4753562C;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [14:0] INT_SAT  = 15'd32767;
    localparam logic [19:0] ALT_SAT  = 20'd1000000;
    localparam logic [27:0] UDEG_SAT = 28'd180000000;

    // floor(x/100) = (x*5243)>>19 for x < 32768
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    // floor(2^32/60); estimate is low by at most one
    localparam logic [26:0] DIV60_MUL  = 27'd71582788;

    localparam int FIFO_DEPTH = 4;

    function automatic logic [19:0] pow10(input logic [2:0] k);
        logic [19:0] r;
        begin
            case (k)
                3'd0:    r = 20'd1;
                3'd1:    r = 20'd10;
                3'd2:    r = 20'd100;
                3'd3:    r = 20'd1000;
                3'd4:    r = 20'd10000;
                3'd5:    r = 20'd100000;
                3'd6:    r = 20'd1000000;
                default: r = 20'd1;
            endcase
            return r;
        end
    endfunction

endpackage

/* design/nrgp_front.sv */
module nrgp_front #(
    parameter int FRACTION_DIGITS = 5,
    parameter int MAX_FIELD_LEN   = 15,
    parameter int MAX_FIELDS      = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          rx_byte,
    input  logic                rx_valid,
    output logic                rx_ready,
    output logic                push,
    output nrgp_pkg::nrgp_evt_t evt,
    input  logic                full
);
    import nrgp_pkg::*;

    logic [31:0]        win_reg, win_next;
    nrgp_kind_t         kind_reg, kind_next;
    logic               in_sent_reg, in_sent_next;
    logic [4:0]         fidx_reg, fidx_next;
    logic [3:0]         fcnt_reg, fcnt_next;
    logic               status_reg, status_next;
    logic [14:0]        lat_i_reg, lat_i_next, lon_i_reg, lon_i_next;
    logic [19:0]        lat_f_reg, lat_f_next, lon_f_reg, lon_f_next;
    logic [2:0]         fdc_reg, fdc_next;
    logic               pt_reg, pt_next;
    logic [19:0]        alt_reg, alt_next;
    logic               neg_reg, neg_next;
    logic signed [20:0] held_reg, held_next;

    logic        acc;
    logic        is_digit;
    logic [3:0]  dig;
    logic        close_lat, close_lon;
    logic [19:0] lat_pad, lon_pad;
    logic [14:0] sel_ip;
    logic [19:0] sel_fp;
    logic [18:0] ip_v;
    logic [23:0] alt_v;

    function automatic logic [19:0] pad_frac(input logic [19:0] f, input logic [2:0] cnt);
        logic [39:0] p;
        begin
            p = {20'd0, f};
            if (cnt < 3'(FRACTION_DIGITS))
                p = f * pow10(3'(FRACTION_DIGITS) - cnt);
            return p[19:0];
        end
    endfunction

    assign rx_ready = !full;
    assign acc      = rx_valid && !full;
    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign dig      = rx_byte[3:0];

    assign close_lat = (kind_reg == KIND_RMC) && (fidx_reg == 5'd2);
    assign close_lon = (kind_reg == KIND_RMC) && (fidx_reg == 5'd4);
    assign lat_pad   = pad_frac(lat_f_reg, fdc_reg);
    assign lon_pad   = pad_frac(lon_f_reg, fdc_reg);

    assign sel_ip = (fidx_reg == 5'd2) ? lat_i_reg : lon_i_reg;
    assign sel_fp = (fidx_reg == 5'd2) ? lat_f_reg : lon_f_reg;
    assign ip_v   = {4'd0, sel_ip} * 19'd10 + {15'd0, dig};
    assign alt_v  = pt_reg ? ({4'd0, alt_reg} + {20'd0, dig})
                           : ({4'd0, alt_reg} * 24'd10 + {20'd0, dig} * 24'd10);

    always_comb
    begin
        win_next     = win_reg;
        kind_next    = kind_reg;
        in_sent_next = in_sent_reg;
        fidx_next    = fidx_reg;
        fcnt_next    = fcnt_reg;
        status_next  = status_reg;
        lat_i_next   = lat_i_reg;
        lat_f_next   = lat_f_reg;
        lon_i_next   = lon_i_reg;
        lon_f_next   = lon_f_reg;
        fdc_next     = fdc_reg;
        pt_next      = pt_reg;
        alt_next     = alt_reg;
        neg_next     = neg_reg;
        held_next    = held_reg;
        push         = 1'b0;

        if (acc)
        begin
            if (!in_sent_reg)
            begin
                win_next = {win_reg[23:0], rx_byte};
                if (win_next == HDR_RMC || win_next == HDR_GGA)
                begin
                    kind_next    = (win_next == HDR_RMC) ? KIND_RMC : KIND_GGA;
                    in_sent_next = 1'b1;
                    fidx_next    = '0;
                    fcnt_next    = '0;
                    status_next  = 1'b0;
                    lat_i_next   = '0;
                    lat_f_next   = '0;
                    lon_i_next   = '0;
                    lon_f_next   = '0;
                    fdc_next     = '0;
                    pt_next      = 1'b0;
                    alt_next     = '0;
                    neg_next     = 1'b0;
                    win_next     = '0;
                end
                else if (win_next == HDR_GSV)
                begin
                    win_next = '0;
                    push     = 1'b1;
                end
            end
            else if (rx_byte == CH_STAR)
            begin
                if (close_lat) lat_f_next = lat_pad;
                if (close_lon) lon_f_next = lon_pad;
                in_sent_next = 1'b0;
                win_next     = '0;
                if (kind_reg != KIND_RMC && status_reg)
                    held_next = neg_reg ? -$signed({1'b0, alt_reg}) : $signed({1'b0, alt_reg});
                push = 1'b1;
            end
            else if (rx_byte == CH_COMMA)
            begin
                if (close_lat) lat_f_next = lat_pad;
                if (close_lon) lon_f_next = lon_pad;
                if (fidx_reg < 5'(MAX_FIELDS)) fidx_next = fidx_reg + 5'd1;
                fcnt_next = '0;
                pt_next   = 1'b0;
                fdc_next  = '0;
            end
            else if (fidx_reg < 5'(MAX_FIELDS) && fcnt_reg < 4'(MAX_FIELD_LEN))
            begin
                if (kind_reg == KIND_RMC)
                begin
                    if (fidx_reg == 5'd1 && fcnt_reg == 4'd0)
                        status_next = (rx_byte == CH_A);
                    else if (fidx_reg == 5'd2 || fidx_reg == 5'd4)
                    begin
                        if (rx_byte == CH_DOT && !pt_reg)
                            pt_next = 1'b1;
                        else if (is_digit)
                        begin
                            if (!pt_reg)
                            begin
                                if (fidx_reg == 5'd2)
                                    lat_i_next = (ip_v > 19'(INT_SAT)) ? INT_SAT : ip_v[14:0];
                                else
                                    lon_i_next = (ip_v > 19'(INT_SAT)) ? INT_SAT : ip_v[14:0];
                            end
                            else if (fdc_reg < 3'(FRACTION_DIGITS))
                            begin
                                if (fidx_reg == 5'd2)
                                    lat_f_next = sel_fp * 20'd10 + {16'd0, dig};
                                else
                                    lon_f_next = sel_fp * 20'd10 + {16'd0, dig};
                                fdc_next = fdc_reg + 3'd1;
                            end
                        end
                    end
                end
                else
                begin
                    if (fidx_reg == 5'd5 && fcnt_reg == 4'd0)
                        status_next = (rx_byte != CH_ZERO);
                    else if (fidx_reg == 5'd8)
                    begin
                        if (rx_byte == CH_MINUS && fcnt_reg == 4'd0)
                            neg_next = 1'b1;
                        else if (rx_byte == CH_DOT && !pt_reg)
                            pt_next = 1'b1;
                        else if (is_digit)
                        begin
                            if (!pt_reg || fdc_reg < 3'd1)
                                alt_next = (alt_v > 24'(ALT_SAT)) ? ALT_SAT : alt_v[19:0];
                            if (pt_reg && fdc_reg < 3'd1)
                                fdc_next = fdc_reg + 3'd1;
                        end
                    end
                end
                fcnt_next = fcnt_reg + 4'd1;
            end
        end
    end

    // GSV reports carry the held altitude and zeros elsewhere; RMC/GGA carry the raw fields
    always_comb
    begin
        evt.kind     = in_sent_reg ? kind_reg : KIND_GSV;
        evt.status   = in_sent_reg ? status_reg : 1'b0;
        evt.lat_int  = in_sent_reg ? lat_i_next : '0;
        evt.lat_frac = in_sent_reg ? lat_f_next : '0;
        evt.lon_int  = in_sent_reg ? lon_i_next : '0;
        evt.lon_frac = in_sent_reg ? lon_f_next : '0;
        evt.alt      = held_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg     <= '0;
            kind_reg    <= KIND_RMC;
            in_sent_reg <= 1'b0;
            fidx_reg    <= '0;
            fcnt_reg    <= '0;
            status_reg  <= 1'b0;
            lat_i_reg   <= '0;
            lat_f_reg   <= '0;
            lon_i_reg   <= '0;
            lon_f_reg   <= '0;
            fdc_reg     <= '0;
            pt_reg      <= 1'b0;
            alt_reg     <= '0;
            neg_reg     <= 1'b0;
            held_reg    <= '0;
        end
        else
        begin
            win_reg     <= win_next;
            kind_reg    <= kind_next;
            in_sent_reg <= in_sent_next;
            fidx_reg    <= fidx_next;
            fcnt_reg    <= fcnt_next;
            status_reg  <= status_next;
            lat_i_reg   <= lat_i_next;
            lat_f_reg   <= lat_f_next;
            lon_i_reg   <= lon_i_next;
            lon_f_reg   <= lon_f_next;
            fdc_reg     <= fdc_next;
            pt_reg      <= pt_next;
            alt_reg     <= alt_next;
            neg_reg     <= neg_next;
            held_reg    <= held_next;
        end
    end

endmodule

/* design/nrgp_fifo.sv */
module nrgp_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  nrgp_pkg::nrgp_qctl_t ctl,
    input  nrgp_pkg::nrgp_evt_t wr_data,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output nrgp_pkg::nrgp_evt_t rd_data
);
    import nrgp_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    nrgp_evt_t       mem_reg [FIFO_DEPTH];
    logic [PW-1:0]   wp_reg, wp_next, rp_reg, rp_next;
    logic [PW:0]     cnt_reg, cnt_next;
    logic            do_pop;

    assign full    = (cnt_reg == (PW+1)'(FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = ctl.push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = do_pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (PW+1)'(ctl.push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* design/nrgp_back.sv */
module nrgp_back #(
    parameter int FRACTION_DIGITS = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    input  nrgp_pkg::nrgp_evt_t head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [79:0]         out_data
);
    import nrgp_pkg::*;

    logic        en;
    logic        v1_reg, v2_reg, v3_reg, vo_reg;
    nrgp_evt_t   e1_reg;
    nrgp_kind_t  k2_reg, k3_reg;
    logic        st2_reg, st3_reg;
    logic signed [20:0] a2_reg, a3_reg;
    logic [8:0]  qd1_reg [2];
    logic [8:0]  qd2_reg [2];
    logic [8:0]  qd3_reg [2];
    logic [26:0] num2_reg [2];
    logic [26:0] num3_reg [2];
    logic [21:0] q0_reg [2];
    logic [79:0] data_reg, data_next;

    logic [14:0] ip [2];
    logic [19:0] fp1 [2];
    logic [27:0] p100 [2];
    logic [6:0]  rem [2];
    logic [39:0] fpw [2];
    logic [26:0] num [2];
    logic [53:0] p60 [2];
    logic [26:0] r60 [2];
    logic [21:0] qm [2];
    logic [28:0] v [2];
    logic [27:0] udeg [2];
    logic        rmc_ok;

    assign en  = !vo_reg || out_ready;
    assign pop = en && !empty;
    assign out_valid = vo_reg;
    assign out_data  = data_reg;

    assign ip[0]  = head.lat_int;
    assign ip[1]  = head.lon_int;
    assign fp1[0] = e1_reg.lat_frac;
    assign fp1[1] = e1_reg.lon_frac;

    // two lanes: latitude, longitude
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            p100[i] = ip[i] * DIV100_MUL;
            rem[i]  = 7'((i == 0 ? e1_reg.lat_int : e1_reg.lon_int) - qd1_reg[i] * 15'd100);
            fpw[i]  = fp1[i] * pow10(3'(6 - FRACTION_DIGITS));
            num[i]  = {20'd0, rem[i]} * 27'd1000000 + fpw[i][26:0];
            p60[i]  = num2_reg[i] * DIV60_MUL;
            r60[i]  = num3_reg[i] - {5'd0, q0_reg[i]} * 27'd60;
            qm[i]   = q0_reg[i] + ((r60[i] >= 27'd60) ? 22'd1 : 22'd0);
            v[i]    = {20'd0, qd3_reg[i]} * 29'd1000000 + {7'd0, qm[i]};
            udeg[i] = (v[i] > 29'(UDEG_SAT)) ? UDEG_SAT : v[i][27:0];
        end
    end

    assign rmc_ok    = (k3_reg == KIND_RMC) && st3_reg;
    assign data_next = {a3_reg,
                        rmc_ok ? udeg[1] : 28'd0,
                        rmc_ok ? udeg[0] : 28'd0,
                        (k3_reg == KIND_GSV) ? 1'b0 : st3_reg,
                        k3_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= !empty;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg   <= head;
            k2_reg   <= e1_reg.kind;
            st2_reg  <= e1_reg.status;
            a2_reg   <= e1_reg.alt;
            k3_reg   <= k2_reg;
            st3_reg  <= st2_reg;
            a3_reg   <= a2_reg;
            data_reg <= data_next;
            for (int i = 0; i < 2; i++)
            begin
                qd1_reg[i]  <= p100[i][27:19];
                qd2_reg[i]  <= qd1_reg[i];
                num2_reg[i] <= num[i];
                qd3_reg[i]  <= qd2_reg[i];
                num3_reg[i] <= num2_reg[i];
                q0_reg[i]   <= p60[i][53:32];
            end
        end
    end

endmodule

/* design/nmea_rmc_gga_parser_top.sv */
// NMEA 0183 sentence parser (RMC / GGA / GSV).
// Input stream: s_tdata[7:0] carries one received character per request.
// Output stream: one request per finished RMC/GGA sentence (at its '*')
// and one per GSV header seen; nothing for other traffic.
// m_tdata fields, low bit up: sentence_kind[1:0], fix_valid[2],
// latitude_udeg[30:3], longitude_udeg[58:31], altitude_dm[79:59] (signed).
// Throughput: one character per cycle while the queue is not full. The
// front parser does one small compare/accumulate per character; the
// coordinate conversion runs in a four-stage multiply pipeline that also
// takes one request per cycle unless a stalled result holds it. Reports
// are queued at the '*' or last header character, then piped to m_tdata.
// A 4-entry queue sits between parser and converter; s_tready drops only
// when it is full, i.e. when the receiver has stalled m_tready for a while.
// The result register holds its request stable while m_tready is low.
// Reset (rst_n low, async) empties the queue and pipeline and clears the
// header window, parser state and the held altitude.
module nmea_rmc_gga_parser_top #(
    parameter int FRACTION_DIGITS = 5,
    parameter int MAX_FIELD_LEN   = 15,
    parameter int MAX_FIELDS      = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // kind[1:0] fix[2] lat[30:3] lon[58:31] alt[79:59]
);
    import nrgp_pkg::*;

    nrgp_evt_t  evt;
    nrgp_evt_t  head;
    nrgp_qctl_t qctl;
    logic       push;
    logic       full;
    logic       empty;
    logic       pop;

    assign qctl.push = push;
    assign qctl.full = full;

    nrgp_front #(
        .FRACTION_DIGITS(FRACTION_DIGITS),
        .MAX_FIELD_LEN  (MAX_FIELD_LEN),
        .MAX_FIELDS     (MAX_FIELDS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx_byte (s_tdata),
        .rx_valid(s_tvalid),
        .rx_ready(s_tready),
        .push    (push),
        .evt     (evt),
        .full    (qctl.full)
    );

    // sentence queue: front and back stall independently
    nrgp_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (qctl),
        .wr_data(evt),
        .full   (full),
        .pop    (pop),
        .empty  (empty),
        .rd_data(head)
    );

    nrgp_back #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .head     (head),
        .pop      (pop),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (m_tdata)
    );

endmodule

/* design/nrgp_checker.sv */
module nrgp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);
    import nrgp_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("bad sentence kind");

    // GSV carries no fix and no position
    a_gsv: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == KIND_GSV |-> m_tdata[58:2] == '0)
        else $error("GSV report with fix or position");

    // GGA carries no position
    a_gga: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == KIND_GGA |-> m_tdata[58:3] == '0)
        else $error("GGA report with position");

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[30:3] <= UDEG_SAT && m_tdata[58:31] <= UDEG_SAT)
        else $error("coordinate beyond saturation");

endmodule

bind nmea_rmc_gga_parser_top nrgp_checker u_nrgp_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

/* test/tb_nmea_rmc_gga_parser_top.sv */
`timescale 1ns / 1ps

module tb_nmea_rmc_gga_parser_top;
    import nrgp_pkg::*;

    localparam int FRAC_DIGITS = 5;
    localparam int FIELD_LEN   = 15;
    localparam int FIELD_MAX   = 20;
    localparam int CYCLE_LIMIT = 2000000;

    // one parsed sentence report
    typedef struct packed {
        logic [1:0]         kind;
        logic               fix;
        logic [27:0]        lat;
        logic [27:0]        lon;
        logic signed [20:0] alt;
    } fix_report_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;

    nmea_rmc_gga_parser_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Parser shadow: mirrors the sentence parser character by character.
    // ------------------------------------------------------------------
    logic [31:0] hdr_win;
    nrgp_kind_t  cur_kind;
    logic        in_sent;
    int unsigned fld_idx, fld_chars;
    logic        stat_ok;
    int unsigned lat_i, lat_f, lon_i, lon_f, frac_n;
    logic        got_dot;
    int unsigned alt_mag;
    logic        alt_neg;
    int          alt_latched;

    fix_report_t pending_reports[$];
    byte         char_queue[$];

    function automatic int unsigned p10(input int unsigned k);
        int unsigned r;
        r = 1;
        repeat (k) r = r * 10;
        return r;
    endfunction

    function automatic logic [27:0] minutes_to_udeg(input int unsigned ip,
                                                    input int unsigned fp);
        longint unsigned mins, v;
        mins = longint'(ip % 100) * p10(FRAC_DIGITS) + fp;
        v = longint'(ip / 100) * 1000000 + mins * 1000000 / (60 * p10(FRAC_DIGITS));
        return (v > 180000000) ? 28'd180000000 : v[27:0];
    endfunction

    task automatic clear_sentence(input nrgp_kind_t k);
        in_sent = 1'b1;   cur_kind = k;
        fld_idx = 0;      fld_chars = 0;  stat_ok = 1'b0;
        lat_i = 0; lat_f = 0; lon_i = 0; lon_f = 0;
        frac_n = 0;       got_dot = 1'b0;
        alt_mag = 0;      alt_neg = 1'b0;
    endtask

    task automatic pad_fraction();
        if (cur_kind == KIND_RMC && frac_n < FRAC_DIGITS)
        begin
            if (fld_idx == 2)      lat_f = lat_f * p10(FRAC_DIGITS - frac_n);
            else if (fld_idx == 4) lon_f = lon_f * p10(FRAC_DIGITS - frac_n);
        end
    endtask

    task automatic coord_digit(input byte c, inout int unsigned ip, inout int unsigned fp);
        int unsigned v;
        if (c == CH_DOT && !got_dot)
            got_dot = 1'b1;
        else if (c >= CH_ZERO && c <= CH_NINE)
        begin
            if (!got_dot)
            begin
                v = ip * 10 + (c - CH_ZERO);
                ip = (v > 32767) ? 32767 : v;
            end
            else if (frac_n < FRAC_DIGITS)
            begin
                fp = fp * 10 + (c - CH_ZERO);
                frac_n++;
            end
        end
    endtask

    task automatic alt_digit(input byte c);
        int unsigned v;
        if (c == CH_MINUS && fld_chars == 0)
            alt_neg = 1'b1;
        else if (c == CH_DOT && !got_dot)
            got_dot = 1'b1;
        else if (c >= CH_ZERO && c <= CH_NINE)
        begin
            if (!got_dot)
                v = alt_mag * 10 + (c - CH_ZERO) * 10;
            else if (frac_n < 1)
            begin
                v = alt_mag + (c - CH_ZERO);
                frac_n++;
            end
            else
                v = alt_mag;
            alt_mag = (v > 1000000) ? 1000000 : v;
        end
    endtask

    task automatic parse_char(input byte c);
        fix_report_t r;
        if (!in_sent)
        begin
            hdr_win = {hdr_win[23:0], c};
            if (hdr_win == HDR_RMC)
            begin
                clear_sentence(KIND_RMC); hdr_win = '0;
            end
            else if (hdr_win == HDR_GGA)
            begin
                clear_sentence(KIND_GGA); hdr_win = '0;
            end
            else if (hdr_win == HDR_GSV)
            begin
                hdr_win = '0;
                r = '{KIND_GSV, 1'b0, 28'd0, 28'd0, alt_latched[20:0]};
                pending_reports.push_back(r);
            end
            return;
        end
        if (c == CH_STAR)
        begin
            pad_fraction();
            in_sent = 1'b0;
            hdr_win = '0;
            r = '{cur_kind, stat_ok, 28'd0, 28'd0, 21'sd0};
            if (cur_kind == KIND_RMC)
            begin
                if (stat_ok)
                begin
                    r.lat = minutes_to_udeg(lat_i, lat_f);
                    r.lon = minutes_to_udeg(lon_i, lon_f);
                end
            end
            else if (stat_ok)
                alt_latched = alt_neg ? -int'(alt_mag) : int'(alt_mag);
            r.alt = alt_latched[20:0];
            pending_reports.push_back(r);
            return;
        end
        if (c == CH_COMMA)
        begin
            pad_fraction();
            if (fld_idx < FIELD_MAX) fld_idx++;
            fld_chars = 0; got_dot = 1'b0; frac_n = 0;
            return;
        end
        if (fld_idx < FIELD_MAX && fld_chars < FIELD_LEN)
        begin
            if (cur_kind == KIND_RMC)
            begin
                if (fld_idx == 1 && fld_chars == 0) stat_ok = (c == CH_A);
                else if (fld_idx == 2) coord_digit(c, lat_i, lat_f);
                else if (fld_idx == 4) coord_digit(c, lon_i, lon_f);
            end
            else
            begin
                if (fld_idx == 5 && fld_chars == 0) stat_ok = (c != CH_ZERO);
                else if (fld_idx == 8) alt_digit(c);
            end
            fld_chars++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus text builders
    // ------------------------------------------------------------------
    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) char_queue.push_back(s[i]);
    endtask

    function automatic string digits(input int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(byte'(CH_ZERO + $urandom_range(0, 9)))};
        return s;
    endfunction

    function automatic string rand_num(input int ni, input int nf);
        string s;
        s = digits(ni);
        if (nf >= 0) s = {s, ".", digits(nf)};
        return s;
    endfunction

    function automatic string noise_field();
        string s;
        int n;
        s = "";
        n = $urandom_range(0, 18);
        for (int i = 0; i < n; i++)
        begin
            byte c;
            case ($urandom_range(0, 5))
                0:       c = byte'($urandom_range(0, 255));
                1:       c = CH_DOT;
                2:       c = CH_MINUS;
                default: c = byte'(CH_ZERO + $urandom_range(0, 9));
            endcase
            if (c == CH_STAR || c == CH_COMMA) c = CH_ZERO;
            s = {s, string'(c)};
        end
        return s;
    endfunction

    task automatic put_rmc();
        string s;
        int nf;
        s = "$GPRMC,";
        s = {s, digits(6), ".00,"};
        case ($urandom_range(0, 3))
            0:       s = {s, "V,"};
            1:       s = {s, ","};
            default: s = {s, "A,"};
        endcase
        s = {s, ($urandom_range(0, 7) == 0) ? noise_field()
                : rand_num($urandom_range(0, 6), $urandom_range(0, 8) - 1), ","};
        s = {s, ($urandom_range(0, 1) ? "N" : "S"), ","};
        s = {s, ($urandom_range(0, 7) == 0) ? noise_field()
                : rand_num($urandom_range(0, 6), $urandom_range(0, 8) - 1)};
        nf = $urandom_range(0, 25);
        for (int i = 0; i < nf; i++) s = {s, ",", ($urandom_range(0, 3) == 0) ? noise_field() : ""};
        s = {s, "*", digits(2), "\r\n"};
        put_str(s);
    endtask

    task automatic put_gga();
        string s;
        int n;
        s = {"$GPGGA,", digits(6), ",", rand_num(4, 4), ",N,", rand_num(5, 4), ",E,"};
        case ($urandom_range(0, 3))
            0:       s = {s, "0"};
            1:       s = {s, ""};
            2:       s = {s, string'(byte'($urandom_range(33, 126) == CH_STAR ? 8'h32 : 8'h31))};
            default: s = {s, "1"};
        endcase
        s = {s, ",08,0.9,"};
        case ($urandom_range(0, 5))
            0:       s = {s, noise_field()};
            1:       s = {s, "-", rand_num($urandom_range(0, 9), $urandom_range(0, 3) - 1)};
            default: s = {s, rand_num($urandom_range(0, 7), $urandom_range(0, 3) - 1)};
        endcase
        n = $urandom_range(0, 20);
        for (int i = 0; i < n; i++) s = {s, ",", ($urandom_range(0, 3) == 0) ? noise_field() : "M"};
        s = {s, "*", digits(2), "\r\n"};
        put_str(s);
    endtask

    task automatic put_noise(input int n);
        for (int i = 0; i < n; i++)
            char_queue.push_back(byte'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts with random gaps
    // ------------------------------------------------------------------
    int  burst_left, gap_left;
    bit  drive_hold;          // sender pause requested by stimulus
    bit  driver_on;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            logic do_offer;
            if (s_tvalid && s_tready)
            begin
                parse_char(s_tdata);
                void'(char_queue.pop_front());
            end
            do_offer = 1'b0;
            if (s_tvalid && !s_tready)
                do_offer = 1'b1;            // keep offering a stalled request
            else if (driver_on && !drive_hold && char_queue.size() > 0)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (burst_left > 0)
                begin
                    do_offer = 1'b1;
                    burst_left <= burst_left - 1;
                end
                else
                begin
                    burst_left <= $urandom_range(1, 60);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            s_tvalid <= do_offer && char_queue.size() > 0;
            if (do_offer && char_queue.size() > 0) s_tdata <= char_queue[0];
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall pattern and long hold-off
    // ------------------------------------------------------------------
    int  stall_phase;
    int  holdoff_left;
    bit  holdoff_req;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            stall_phase  <= 0;
            holdoff_left <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (holdoff_req && holdoff_left == 0)
                holdoff_left <= 2000;
            if (holdoff_left > 0)
            begin
                holdoff_left <= holdoff_left - 1;
                m_tready <= 1'b0;
            end
            else if (stall_phase[9:8] == 2'b11)
                m_tready <= 1'b1;           // stretch with no stalls
            else
                m_tready <= ($urandom_range(0, 3) != 0) && (stall_phase % 13 != 5);
        end
    end

    // ------------------------------------------------------------------
    // Monitor / checker
    // ------------------------------------------------------------------
    int mismatches;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            fix_report_t got, want;
            got.kind = m_tdata[1:0];
            got.fix  = m_tdata[2];
            got.lat  = m_tdata[30:3];
            got.lon  = m_tdata[58:31];
            got.alt  = m_tdata[79:59];
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected report kind=%0d fix=%0d lat=%0d lon=%0d alt=%0d",
                             got.kind, got.fix, got.lat, got.lon, got.alt);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"report mismatch: exp kind=%0d fix=%0d lat=%0d lon=%0d",
                                  " alt=%0d | got kind=%0d fix=%0d lat=%0d lon=%0d alt=%0d"},
                                 want.kind, want.fix, want.lat, want.lon, want.alt,
                                 got.kind, got.fix, got.lat, got.lon, got.alt);
                end
            end
        end
    end

    // watchdog
    int cycles;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        while (char_queue.size() > 0 || s_tvalid || pending_reports.size() > 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        driver_on = 1'b0; drive_hold = 1'b0; holdoff_req = 1'b0;
        mismatches = 0;
        hdr_win = '0; in_sent = 1'b0; cur_kind = KIND_RMC;
        fld_idx = 0; fld_chars = 0; stat_ok = 1'b0;
        lat_i = 0; lat_f = 0; lon_i = 0; lon_f = 0; frac_n = 0;
        got_dot = 1'b0; alt_mag = 0; alt_neg = 1'b0; alt_latched = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes of coordinates, GG5 spelling, GSV, broken header
        put_str("RMC,0,A,99999.999999,N,9999999999,E*00");
        put_str("GGA,1,2,3,4,5,9,7,-99999999.99*1");
        put_str("GSV,x");
        put_str("RMC,1,V,4807.038,N,01131.000,E*");
        put_str("GGA,,,,,,0,,,545.4*");
        put_str("GG5,");
        char_queue.push_back(8'hFF);
        char_queue.push_back(8'h00);
        driver_on = 1'b1;
        wait_drained();

        // first random part, then a long receiver hold-off with sender active
        for (int i = 0; i < 8; i++) if ($urandom_range(0, 1)) put_rmc(); else put_gga();
        holdoff_req = 1'b1;
        wait (holdoff_left > 0);
        holdoff_req = 1'b0;
        for (int i = 0; i < 4; i++) put_str("GSV,");
        wait_drained();

        // sender pause until all reports are in, then the bulk
        drive_hold = 1'b1;
        wait_drained();
        drive_hold = 1'b0;
        while (char_queue.size() < 1100 || 1)
        begin
            case ($urandom_range(0, 9))
                0:       put_noise($urandom_range(1, 30));
                1:       put_str("GSV,");
                2, 3, 4: put_gga();
                default: put_rmc();
            endcase
            if (char_queue.size() >= 1100) break;
        end
        wait_drained();
        repeat (20) @(posedge clk);

        if (mismatches == 0 && pending_reports.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
